// ----- sv/uph_pkg.sv -----
// Package for the URI path djb2 bucket block.
// Shared widths, constants and the queue entry type; no dependencies.
package uph_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HASH_W     = 64;
    localparam int unsigned IDX_W      = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [HASH_W-1:0] DJB2_SEED  = HASH_W'(5381);
    localparam logic [BYTE_W-1:0] QUERY_MARK = 8'h3F;
    localparam logic [BYTE_W-1:0] URI_END    = 8'h00;
    localparam int unsigned        DJB2_SHIFT = 5;

    localparam logic [IDX_W-1:0]  TABLE_SIZE_RST = IDX_W'(1024);

    // register index, decoded from paddr above the byte offset
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_hash_push;

endpackage

// ----- sv/uph_front.sv -----
// Front end: takes URI bytes, runs the djb2 hash over the path part.
// Pushes the finished hash into the queue on a terminating zero byte. Uses uph_pkg.
module uph_front
    import uph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_q_full,
    output logic              o_ready,
    output t_hash_push        o_push
);

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic              r_in_query;
    logic              n_in_query;
    logic              w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    assign o_push.valid = w_accept && (i_byte == URI_END);
    assign o_push.hash  = r_hash;

    always_comb begin
        n_hash     = r_hash;
        n_in_query = r_in_query;
        if (w_accept) begin
            if (i_byte == URI_END) begin
                n_hash     = DJB2_SEED;
                n_in_query = 1'b0;
            end else if (!r_in_query) begin
                if (i_byte == QUERY_MARK) begin
                    n_in_query = 1'b1;
                end else begin
                    // hash*33 + byte, wrapping
                    n_hash = (r_hash << DJB2_SHIFT) + r_hash + HASH_W'(i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= DJB2_SEED;
            r_in_query <= 1'b0;
        end else begin
            r_hash     <= n_hash;
            r_in_query <= n_in_query;
        end
    end

endmodule

// ----- sv/uph_queue.sv -----
// Short queue of finished hashes between front end and divider.
// Flip-flop storage, one push and one pop per cycle. Uses uph_pkg.
module uph_queue
    import uph_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hash_push        i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [HASH_W-1:0] o_head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push.valid && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/uph_div.sv -----
// Back end: restoring divider, one quotient bit per cycle, giving hash mod table size.
// Holds the result in an output register until taken. Uses uph_pkg.
module uph_div
    import uph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  logic [HASH_W-1:0] i_q_head,
    input  logic [IDX_W-1:0]  i_table_size,
    input  logic              i_m_ready,
    output logic              o_q_pop,
    output logic              o_m_valid,
    output logic [IDX_W-1:0]  o_m_data
);

    localparam int unsigned CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [HASH_W-1:0] r_dvd;
    logic [IDX_W-1:0]  r_rem;
    logic [IDX_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_data;
    logic [IDX_W:0]    w_shift;
    logic [IDX_W:0]    w_diff;
    logic              w_take;

    assign w_shift = {r_rem, r_dvd[HASH_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign w_take  = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && i_m_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_dvd   <= i_q_head;
                        r_rem   <= '0;
                        r_dsr   <= i_table_size;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_dvd <= r_dvd << 1;
                    // remainder stays below the divisor, so the low bits suffice
                    if (w_diff[IDX_W] == 1'b0) begin
                        r_rem <= w_diff[IDX_W-1:0];
                    end else begin
                        r_rem <= w_shift[IDX_W-1:0];
                    end
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_take) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= (r_dsr == '0) ? '0 : r_rem;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/url_path_djb2_bucket.sv -----
// Top level of the URI path djb2 bucket block.
// Holds the APB register and joins uph_front, uph_queue and uph_div. Uses uph_pkg.
//
// Usage:
//   Slave stream s_*: one URI byte per transaction in s_tdata[7:0]. A zero byte ends
//   the URI. Bytes from the first '?' on are query and are not hashed.
//   Master stream m_*: one transaction per URI, the bucket index in m_tdata,
//   i.e. the 64-bit djb2 hash of the path modulo table_size (0 if table_size is 0).
//   APB: table_size at address 0, reset 1024. Write it only while no URI is in flight.
// Throughput: one byte per cycle on the slave side while the queue is not full. Each
//   bucket passes through the bit-serial divider (64 steps plus load and hand-over),
//   which takes one hash at a time; up to QDEPTH finished hashes wait in the queue.
// Path: the terminating byte pushes the hash into the queue; a free divider loads it,
//   runs its steps and places the bucket index in the output register.
// Stall: a held master side keeps the result in the output register; the divider
//   then waits, the queue fills, and s_tready drops once the queue is full.
// Reset: synchronous, active low; clears the hash to 5381, the query flag, the
//   queue and m_tvalid, and sets table_size to 1024.
module url_path_djb2_bucket
    import uph_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] uri_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [IDX_W-1:0]      m_tdata,   // [31:0] bucket_index
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [IDX_W-1:0]  r_table_size;
    logic              w_reg_sel;
    t_hash_push        w_push;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_q_pop;
    logic [HASH_W-1:0] w_q_head;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_TABLE_SIZE);
    assign prdata    = w_reg_sel ? APB_DATA_W'(r_table_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_table_size <= pwdata[IDX_W-1:0];
        end
    end

    uph_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_byte   (s_tdata),
        .i_q_full (w_q_full),
        .o_ready  (s_tready),
        .o_push   (w_push)
    );

    uph_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    uph_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_head     (w_q_head),
        .i_table_size (r_table_size),
        .i_m_ready    (m_tready),
        .o_q_pop      (w_q_pop),
        .o_m_valid    (m_tvalid),
        .o_m_data     (m_tdata)
    );

endmodule
